>>> rtl/reader_writer_lock_table_core_defines.svh
// Assertion macros used by the lock table sequencer.
`ifndef READER_WRITER_LOCK_TABLE_CORE_DEFINES_SVH
`define READER_WRITER_LOCK_TABLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RWLT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rwlt assertion failed");
`define RWLT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("rwlt forbidden condition seen");
`else
`define RWLT_ASSERT(lbl, clk, rstn, prop)
`define RWLT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> rtl/rwlt_pkg.sv
// Types, constants and helpers of the lock table.
`timescale 1ns / 1ps
package rwlt_pkg;

  localparam int NUM_KEYS    = 256;
  localparam int MAX_HOLDERS = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int RESULT_CAP  = 16;
  localparam int TXN_W       = 16;

  localparam int GRANT_MAX = (MAX_HOLDERS < RESULT_CAP) ? MAX_HOLDERS : RESULT_CAP;

  localparam int KEY_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int HCNT_W = $clog2(MAX_HOLDERS + 1);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_W  = (HCNT_W > QCNT_W) ? HCNT_W : QCNT_W;
  localparam int HIDX_W = (MAX_HOLDERS > 1) ? $clog2(MAX_HOLDERS) : 1;
  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int GCNT_W = $clog2(GRANT_MAX + 1);
  localparam int GIDX_W = (GRANT_MAX > 1) ? $clog2(GRANT_MAX) : 1;

  localparam int HOLD_DEPTH = NUM_KEYS * MAX_HOLDERS;
  localparam int QUE_DEPTH  = NUM_KEYS * QUEUE_DEPTH;
  localparam int HADDR_W    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int QADDR_W    = (QUE_DEPTH > 1) ? $clog2(QUE_DEPTH) : 1;

  typedef enum logic [1:0] {
    FUNC_READ    = 2'd0,
    FUNC_WRITE   = 2'd1,
    FUNC_RELEASE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    MODE_FREE  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_GRANT    = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_FULL     = 3'd2,
    ST_RELEASED = 3'd3,
    ST_WAKE     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_META,
    S_HSCAN,
    S_HDEC,
    S_QCOMP,
    S_QRUN,
    S_QSHIFT,
    S_RESP,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [7:0]       key_slot;
    logic [TXN_W-1:0] txn_id;
  } req_t;

  typedef struct packed {
    logic [TXN_W-1:0] out_txn;
    logic [2:0]       status;
    logic             last;
  } rsp_t;

  typedef struct packed {
    mode_e             mode;
    logic [HCNT_W-1:0] hcnt;
    logic [QCNT_W-1:0] qcnt;
  } meta_t;

  typedef struct packed {
    logic             wr;
    logic [TXN_W-1:0] txn;
  } qent_t;

  typedef struct packed {
    logic             re;
    logic [KEY_W-1:0] raddr;
    logic             we;
    logic [KEY_W-1:0] waddr;
    meta_t            wdata;
  } meta_req_t;

  typedef struct packed {
    logic               re;
    logic [HADDR_W-1:0] raddr;
    logic               we;
    logic [HADDR_W-1:0] waddr;
    logic [TXN_W-1:0]   wdata;
  } hold_req_t;

  typedef struct packed {
    logic               re;
    logic [QADDR_W-1:0] raddr;
    logic               we;
    logic [QADDR_W-1:0] waddr;
    qent_t              wdata;
  } que_req_t;

  function automatic logic [HADDR_W-1:0] hold_addr(input logic [KEY_W-1:0] key,
                                                   input logic [HIDX_W-1:0] idx);
    return HADDR_W'(int'(key) * MAX_HOLDERS + int'(idx));
  endfunction

  function automatic logic [QADDR_W-1:0] que_addr(input logic [KEY_W-1:0] key,
                                                  input logic [QIDX_W-1:0] idx);
    return QADDR_W'(int'(key) * QUEUE_DEPTH + int'(idx));
  endfunction

endpackage

>>> rtl/rwlt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module rwlt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rwlt_meta.sv
// Per-key lock mode and counters, with valid bits so reset reads as unlocked.
`timescale 1ns / 1ps
module rwlt_meta (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rwlt_pkg::meta_req_t req_i,
  output rwlt_pkg::meta_t     rdata_o
);
  import rwlt_pkg::*;

  meta_t               mem [NUM_KEYS];
  meta_t               rdata_q;
  logic [NUM_KEYS-1:0] vld_q;
  logic                rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvld_q <= vld_q[req_i.raddr];
      end
    end
  end

  // an entry never written reads as free with empty holder set and queue
  always_comb begin
    rdata_o.mode = MODE_FREE;
    rdata_o.hcnt = '0;
    rdata_o.qcnt = '0;
    if (rvld_q) begin
      rdata_o = rdata_q;
    end
  end

endmodule

>>> rtl/rwlt_seq.sv
// Sequencer: read-modify-write of lock entries, holder search, queue compaction, waiter wake-up.
`timescale 1ns / 1ps
`include "reader_writer_lock_table_core_defines.svh"
module rwlt_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rwlt_pkg::req_t      in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rwlt_pkg::rsp_t      out_o,
  output rwlt_pkg::meta_req_t meta_req_o,
  input  rwlt_pkg::meta_t     meta_rdata_i,
  output rwlt_pkg::hold_req_t hold_req_o,
  input  logic [rwlt_pkg::TXN_W-1:0] hold_rdata_i,
  output rwlt_pkg::que_req_t  que_req_o,
  input  rwlt_pkg::qent_t     que_rdata_i
);
  import rwlt_pkg::*;

  state_e            state_q, state_d;
  req_t              req_q, req_d;
  logic [KEY_W-1:0]  key_q, key_d;
  meta_t             meta_q, meta_d;
  logic [CNT_W-1:0]  ridx_q, ridx_d;
  logic              dv_q, dv_d;
  logic [CNT_W-1:0]  didx_q, didx_d;
  logic [QCNT_W-1:0] widx_q, widx_d;
  logic              found_q, found_d;
  logic [HIDX_W-1:0] pos_q, pos_d;
  logic [TXN_W-1:0]  hlast_q, hlast_d;
  logic [GCNT_W-1:0] gcnt_q, gcnt_d;
  logic [TXN_W-1:0]  gnt_q [GRANT_MAX];
  logic [TXN_W-1:0]  gnt_d [GRANT_MAX];
  logic [QCNT_W-1:0] cons_q, cons_d;
  logic [GCNT_W-1:0] emit_q, emit_d;
  mode_e             rmode_q, rmode_d;
  status_e           res_q, res_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  // decisions shared by next-state and datapath
  logic              key_ok, func_ok, out_free;
  logic              rd_share, q_full;
  logic [CNT_W-1:0]  lim;
  logic              issue, stream_done;
  logic              in_gnt, head_wr, run_stop;
  logic [QCNT_W-1:0] run_cons, run_left;
  logic [HCNT_W-1:0] h_left;

  always_comb begin
    key_ok   = int'(req_q.key_slot) < NUM_KEYS;
    func_ok  = (req_q.func == FUNC_READ) || (req_q.func == FUNC_WRITE) ||
               (req_q.func == FUNC_RELEASE);
    out_free = !out_valid_q || out_ready_i;
    rd_share = (meta_rdata_i.mode == MODE_READ) && (meta_rdata_i.qcnt == '0);
    q_full   = meta_rdata_i.qcnt >= QCNT_W'(QUEUE_DEPTH);
    h_left   = meta_q.hcnt - HCNT_W'(1);

    lim = (state_q == S_HSCAN) ? CNT_W'(meta_q.hcnt) : CNT_W'(meta_q.qcnt);
    issue       = ridx_q < lim;
    stream_done = dv_q && (didx_q == lim - CNT_W'(1));

    in_gnt = 1'b0;
    for (int k = 0; k < GRANT_MAX; k++) begin
      if ((GCNT_W'(k) < gcnt_q) && (gnt_q[k] == que_rdata_i.txn)) begin
        in_gnt = 1'b1;
      end
    end
    head_wr  = que_rdata_i.wr && (didx_q == '0);
    run_stop = dv_q && (que_rdata_i.wr || (gcnt_q >= GCNT_W'(GRANT_MAX)) ||
                        (didx_q == lim - CNT_W'(1)));
    if (head_wr) begin
      run_cons = QCNT_W'(1);
    end else if (que_rdata_i.wr || (gcnt_q >= GCNT_W'(GRANT_MAX))) begin
      run_cons = QCNT_W'(didx_q);
    end else begin
      run_cons = meta_q.qcnt;
    end
    run_left = meta_q.qcnt - run_cons;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_META;
      end
      S_META: begin
        state_d = S_RESP;
        if (key_ok && func_ok) begin
          if (req_q.func == FUNC_READ) begin
            if (rd_share) state_d = S_HSCAN;
          end else if (req_q.func == FUNC_RELEASE) begin
            if (meta_rdata_i.hcnt != '0) begin
              state_d = S_HSCAN;
            end else if (meta_rdata_i.qcnt != '0) begin
              state_d = S_QCOMP;
            end
          end
        end
      end
      S_HSCAN: begin
        if (stream_done) state_d = S_HDEC;
      end
      S_HDEC: begin
        state_d = S_RESP;
        if (req_q.func == FUNC_RELEASE) begin
          if (!found_q) begin
            if (meta_q.qcnt != '0) state_d = S_QCOMP;
          end else if (h_left == '0 && meta_q.qcnt != '0) begin
            state_d = S_QRUN;
          end
        end
      end
      S_QCOMP: begin
        if (stream_done) state_d = S_RESP;
      end
      S_QRUN: begin
        if (run_stop) state_d = (run_left != '0) ? S_QSHIFT : S_EMIT;
      end
      S_QSHIFT: begin
        if (stream_done) state_d = S_EMIT;
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      S_EMIT: begin
        if (out_free && (emit_q == gcnt_q - GCNT_W'(1))) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    req_d   = req_q;
    key_d   = key_q;
    meta_d  = meta_q;
    ridx_d  = ridx_q;
    dv_d    = 1'b0;
    didx_d  = didx_q;
    widx_d  = widx_q;
    found_d = found_q;
    pos_d   = pos_q;
    hlast_d = hlast_q;
    gcnt_d  = gcnt_q;
    gnt_d   = gnt_q;
    cons_d  = cons_q;
    emit_d  = emit_q;
    rmode_d = rmode_q;
    res_d   = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d   = out_q;
    in_ready_o = 1'b0;
    meta_req_o = '0;
    hold_req_o = '0;
    que_req_o  = '0;

    // read streaming used by the scan, compaction, run and shift phases
    if (state_q == S_HSCAN || state_q == S_QCOMP || state_q == S_QRUN ||
        state_q == S_QSHIFT) begin
      if (issue) begin
        ridx_d = ridx_q + CNT_W'(1);
        hold_req_o.re    = (state_q == S_HSCAN);
        hold_req_o.raddr = hold_addr(key_q, HIDX_W'(ridx_q));
        que_req_o.re     = (state_q != S_HSCAN);
        que_req_o.raddr  = que_addr(key_q, QIDX_W'(ridx_q));
      end
      dv_d   = issue;
      didx_d = ridx_q;
    end

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d = in_i;
          key_d = KEY_W'(in_i.key_slot);
          meta_req_o.re    = 1'b1;
          meta_req_o.raddr = KEY_W'(in_i.key_slot);
        end
      end
      S_META: begin
        meta_d  = meta_rdata_i;
        ridx_d  = '0;
        widx_d  = '0;
        found_d = 1'b0;
        res_d   = ST_FULL;
        meta_req_o.waddr = key_q;
        meta_req_o.wdata = meta_rdata_i;
        hold_req_o.waddr = hold_addr(key_q, '0);
        hold_req_o.wdata = req_q.txn_id;
        que_req_o.waddr  = que_addr(key_q, QIDX_W'(meta_rdata_i.qcnt));
        que_req_o.wdata.wr  = (req_q.func == FUNC_WRITE);
        que_req_o.wdata.txn = req_q.txn_id;
        if (key_ok && (req_q.func == FUNC_READ || req_q.func == FUNC_WRITE)) begin
          if (meta_rdata_i.mode == MODE_FREE) begin
            // grant first holder
            hold_req_o.we         = 1'b1;
            meta_req_o.we         = 1'b1;
            meta_req_o.wdata.mode = (req_q.func == FUNC_WRITE) ? MODE_WRITE : MODE_READ;
            meta_req_o.wdata.hcnt = HCNT_W'(1);
            res_d = ST_GRANT;
          end else if (!(req_q.func == FUNC_READ && rd_share)) begin
            // join the queue unless it is full
            if (!q_full) begin
              que_req_o.we          = 1'b1;
              meta_req_o.we         = 1'b1;
              meta_req_o.wdata.qcnt = meta_rdata_i.qcnt + QCNT_W'(1);
              res_d = ST_QUEUED;
            end
          end
        end else if (key_ok && req_q.func == FUNC_RELEASE) begin
          res_d = ST_RELEASED;
        end
      end
      S_HSCAN: begin
        if (dv_q) begin
          if (hold_rdata_i == req_q.txn_id) begin
            found_d = 1'b1;
            pos_d   = HIDX_W'(didx_q);
          end
          hlast_d = hold_rdata_i;
        end
      end
      S_HDEC: begin
        ridx_d = '0;
        widx_d = '0;
        gcnt_d = '0;
        meta_req_o.waddr = key_q;
        meta_req_o.wdata = meta_q;
        if (req_q.func == FUNC_READ) begin
          res_d = ST_GRANT;
          if (!found_q) begin
            if (meta_q.hcnt >= HCNT_W'(MAX_HOLDERS)) begin
              res_d = ST_FULL;
            end else begin
              hold_req_o.we    = 1'b1;
              hold_req_o.waddr = hold_addr(key_q, HIDX_W'(meta_q.hcnt));
              hold_req_o.wdata = req_q.txn_id;
              meta_req_o.we    = 1'b1;
              meta_req_o.wdata.hcnt = meta_q.hcnt + HCNT_W'(1);
            end
          end
        end else begin
          res_d = ST_RELEASED;
          if (found_q) begin
            // move the last holder into the freed slot
            hold_req_o.we    = 1'b1;
            hold_req_o.waddr = hold_addr(key_q, pos_q);
            hold_req_o.wdata = hlast_q;
            if (h_left != '0) begin
              meta_req_o.we = 1'b1;
              meta_req_o.wdata.hcnt = h_left;
            end else if (meta_q.qcnt == '0) begin
              meta_req_o.we = 1'b1;
              meta_req_o.wdata.mode = MODE_FREE;
              meta_req_o.wdata.hcnt = '0;
            end
          end
        end
      end
      S_QCOMP: begin
        que_req_o.waddr = que_addr(key_q, QIDX_W'(widx_q));
        que_req_o.wdata = que_rdata_i;
        if (dv_q && (que_rdata_i.txn != req_q.txn_id)) begin
          que_req_o.we = 1'b1;
          widx_d = widx_q + QCNT_W'(1);
        end
        if (stream_done) begin
          meta_req_o.we    = 1'b1;
          meta_req_o.waddr = key_q;
          meta_req_o.wdata = meta_q;
          meta_req_o.wdata.qcnt = widx_d;
        end
      end
      S_QRUN: begin
        hold_req_o.waddr = hold_addr(key_q, HIDX_W'(gcnt_q));
        hold_req_o.wdata = que_rdata_i.txn;
        if (dv_q) begin
          rmode_d = MODE_READ;
          if (head_wr) begin
            hold_req_o.we = 1'b1;
            gnt_d[0] = que_rdata_i.txn;
            gcnt_d   = GCNT_W'(1);
            rmode_d  = MODE_WRITE;
          end else if (!que_rdata_i.wr && (gcnt_q < GCNT_W'(GRANT_MAX)) && !in_gnt) begin
            hold_req_o.we = 1'b1;
            gnt_d[GIDX_W'(gcnt_q)] = que_rdata_i.txn;
            gcnt_d = gcnt_q + GCNT_W'(1);
          end
        end
        if (run_stop) begin
          cons_d = run_cons;
          ridx_d = CNT_W'(run_cons);
          widx_d = '0;
          dv_d   = 1'b0;
          emit_d = '0;
          if (run_left == '0) begin
            meta_req_o.we    = 1'b1;
            meta_req_o.waddr = key_q;
            meta_req_o.wdata.mode = rmode_d;
            meta_req_o.wdata.hcnt = HCNT_W'(gcnt_d);
            meta_req_o.wdata.qcnt = '0;
          end
        end
      end
      S_QSHIFT: begin
        que_req_o.waddr = que_addr(key_q, QIDX_W'(widx_q));
        que_req_o.wdata = que_rdata_i;
        if (dv_q) begin
          que_req_o.we = 1'b1;
          widx_d = widx_q + QCNT_W'(1);
        end
        if (stream_done) begin
          meta_req_o.we    = 1'b1;
          meta_req_o.waddr = key_q;
          meta_req_o.wdata.mode = rmode_q;
          meta_req_o.wdata.hcnt = HCNT_W'(gcnt_q);
          meta_req_o.wdata.qcnt = meta_q.qcnt - cons_q;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_d.out_txn = req_q.txn_id;
          out_d.status  = res_q;
          out_d.last    = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_d.out_txn = gnt_q[GIDX_W'(emit_q)];
          out_d.status  = ST_WAKE;
          out_d.last    = (emit_q == gcnt_q - GCNT_W'(1));
          emit_d        = emit_q + GCNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      dv_q        <= 1'b0;
      gcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      dv_q        <= dv_d;
      gcnt_q      <= gcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    key_q   <= key_d;
    meta_q  <= meta_d;
    ridx_q  <= ridx_d;
    didx_q  <= didx_d;
    widx_q  <= widx_d;
    found_q <= found_d;
    pos_q   <= pos_d;
    hlast_q <= hlast_d;
    gnt_q   <= gnt_d;
    cons_q  <= cons_d;
    emit_q  <= emit_d;
    rmode_q <= rmode_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `RWLT_ASSERT(a_accept_to_meta, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == S_META))
  `RWLT_NEVER(a_grant_count, clk_i, rst_ni, gcnt_q > GCNT_W'(GRANT_MAX))
  `RWLT_ASSERT(a_pos_in_set, clk_i, rst_ni, (state_q == S_HDEC && found_q) |-> (HCNT_W'(pos_q) < meta_q.hcnt))
  `RWLT_ASSERT(a_run_has_queue, clk_i, rst_ni, (state_q == S_QRUN) |-> (meta_q.qcnt != '0))

endmodule

>>> rtl/reader_writer_lock_table_core.sv
// Top level of the reader/writer lock table.
//
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   in_i  (func, key_slot, txn_id)
// out      output     out_valid_o / out_ready_i out_o (out_txn, status, last)
//
// One transaction at a time. An acquire on a free key or a queue append
// reads and writes the lock entry, then responds; one that checks a shared
// holder set adds a holder scan through the holder RAM read port.
// A release scans holders, then compacts or drains the waiter queue one
// entry per cycle and emits one wake-up per cycle while the output is ready.
// Reset clears lock entries through per-key valid bits: no clearing pass.
// A stalled output holds the sequencer in its response or emit state; input
// stays ready only while idle.
`timescale 1ns / 1ps
module reader_writer_lock_table_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rwlt_pkg::req_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rwlt_pkg::rsp_t out_o
);
  import rwlt_pkg::*;

  meta_req_t        meta_req;
  meta_t            meta_rdata;
  hold_req_t        hold_req;
  logic [TXN_W-1:0] hold_rdata;
  que_req_t         que_req;
  logic [$bits(qent_t)-1:0] que_rdata;

  // per-key mode and counters
  rwlt_meta u_meta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (meta_req),
    .rdata_o (meta_rdata)
  );

  // holder ids, MAX_HOLDERS slots per key
  rwlt_ram #(
    .DEPTH (HOLD_DEPTH),
    .WIDTH (TXN_W)
  ) u_hold_ram (
    .clk_i   (clk_i),
    .we_i    (hold_req.we),
    .waddr_i (hold_req.waddr),
    .wdata_i (hold_req.wdata),
    .re_i    (hold_req.re),
    .raddr_i (hold_req.raddr),
    .rdata_o (hold_rdata)
  );

  // waiter queue entries, QUEUE_DEPTH slots per key, head at slot zero
  rwlt_ram #(
    .DEPTH (QUE_DEPTH),
    .WIDTH ($bits(qent_t))
  ) u_que_ram (
    .clk_i   (clk_i),
    .we_i    (que_req.we),
    .waddr_i (que_req.waddr),
    .wdata_i (que_req.wdata),
    .re_i    (que_req.re),
    .raddr_i (que_req.raddr),
    .rdata_o (que_rdata)
  );

  // request sequencer and output register
  rwlt_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (out_o),
    .meta_req_o   (meta_req),
    .meta_rdata_i (meta_rdata),
    .hold_req_o   (hold_req),
    .hold_rdata_i (hold_rdata),
    .que_req_o    (que_req),
    .que_rdata_i  (qent_t'(que_rdata))
  );

endmodule

>>> dv/reader_writer_lock_table_core_tb.sv
// Self-checking testbench of the reader/writer lock table core.
`timescale 1ns / 1ps
module reader_writer_lock_table_core_tb;
  import rwlt_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Lock table shadow and the queue of expected responses.
  class lock_scoreboard;
    mode_e       mode  [NUM_KEYS];
    logic [15:0] hids  [NUM_KEYS][$];
    qent_t       waitq [NUM_KEYS][$];
    rsp_t        pending[$];
    int          errors;

    function new();
      for (int k = 0; k < NUM_KEYS; k++) mode[k] = MODE_FREE;
      errors = 0;
    endfunction

    function automatic bit is_holder(int k, logic [15:0] t);
      for (int i = 0; i < hids[k].size(); i++) if (hids[k][i] == t) return 1;
      return 0;
    endfunction

    function automatic void push(logic [15:0] t, status_e st);
      rsp_t r;
      r.out_txn = t;
      r.status  = st;
      r.last    = 1'b0;
      pending = {pending, r};
    endfunction

    function automatic status_e enqueue(int k, logic [15:0] t, logic wr);
      qent_t e;
      if (waitq[k].size() >= QUEUE_DEPTH) return ST_FULL;
      e.wr  = wr;
      e.txn = t;
      waitq[k] = {waitq[k], e};
      return ST_QUEUED;
    endfunction

    function automatic void release_lock(int k, logic [15:0] t);
      qent_t rest[$];
      int    pos;
      int    n;
      pos = -1;
      n   = 0;
      for (int i = 0; i < hids[k].size(); i++) if (pos < 0 && hids[k][i] == t) pos = i;
      if (pos < 0) begin
        // drop every queued request of a non-holder
        for (int i = 0; i < waitq[k].size(); i++) begin
          if (waitq[k][i].txn != t) rest = {rest, waitq[k][i]};
        end
        waitq[k] = rest;
        push(t, ST_RELEASED);
        return;
      end
      hids[k].delete(pos);
      if (hids[k].size() != 0) begin
        push(t, ST_RELEASED);
        return;
      end
      if (waitq[k].size() == 0) begin
        mode[k] = MODE_FREE;
        push(t, ST_RELEASED);
        return;
      end
      if (waitq[k][0].wr) begin
        hids[k] = {hids[k], waitq[k][0].txn};
        mode[k] = MODE_WRITE;
        push(waitq[k][0].txn, ST_WAKE);
        waitq[k].delete(0);
      end else begin
        // grant the leading run of readers
        while (waitq[k].size() > 0 && !waitq[k][0].wr &&
               hids[k].size() < MAX_HOLDERS && n < RESULT_CAP) begin
          if (!is_holder(k, waitq[k][0].txn)) begin
            hids[k] = {hids[k], waitq[k][0].txn};
            push(waitq[k][0].txn, ST_WAKE);
            n++;
          end
          waitq[k].delete(0);
        end
        mode[k] = MODE_READ;
      end
    endfunction

    function automatic void note_request(req_t q);
      int      k;
      int      before_n;
      status_e st;
      k = q.key_slot;
      before_n = pending.size();
      if (k >= NUM_KEYS || q.func == FUNC_UNUSED) push(q.txn_id, ST_FULL);
      else if (q.func == FUNC_READ) begin
        if (mode[k] == MODE_FREE) begin
          mode[k] = MODE_READ;
          hids[k] = {q.txn_id};
          st = ST_GRANT;
        end else if (mode[k] == MODE_READ && waitq[k].size() == 0) begin
          if (is_holder(k, q.txn_id)) st = ST_GRANT;
          else if (hids[k].size() >= MAX_HOLDERS) st = ST_FULL;
          else begin
            hids[k] = {hids[k], q.txn_id};
            st = ST_GRANT;
          end
        end else st = enqueue(k, q.txn_id, 1'b0);
        push(q.txn_id, st);
      end else if (q.func == FUNC_WRITE) begin
        if (mode[k] == MODE_FREE) begin
          mode[k] = MODE_WRITE;
          hids[k] = {q.txn_id};
          st = ST_GRANT;
        end else st = enqueue(k, q.txn_id, 1'b1);
        push(q.txn_id, st);
      end else release_lock(k, q.txn_id);
      if (pending.size() > before_n) pending[pending.size()-1].last = 1'b1;
    endfunction

    function automatic void check_response(rsp_t got);
      rsp_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response actual=%h", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending[0];
      pending.delete(0);
      if (got.out_txn !== exp_r.out_txn || got.status !== exp_r.status ||
          got.last !== exp_r.last) begin
        $display("%0t: response mismatch expected txn=%h st=%0d last=%0d",
                 $realtime, exp_r.out_txn, exp_r.status, exp_r.last);
        $display("%0t:                   actual   txn=%h st=%0d last=%0d",
                 $realtime, got.out_txn, got.status, got.last);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_o;

  lock_scoreboard sb;
  int  idle_cycles;
  bit  out_idle_on;

  reader_writer_lock_table_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Send one request: optional gap, hold valid until accepted.
  task automatic send_req(logic [1:0] f, logic [7:0] k, logic [15:0] t);
    int gap;
    gap = out_idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= '{func: f, key_slot: k, txn_id: t};
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(in_i);
  endtask

  // Receiver: draw a stall per response, then raise ready until one arrives.
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = out_idle_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_response(out_o);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [1:0]  f;
    logic [7:0]  k;
    logic [15:0] t;
    sb = new();
    idle_cycles = 0;
    out_idle_on = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, each func, full holder set, full queue, run grant.
    send_req(FUNC_READ, 8'd0, 16'h0000);
    send_req(FUNC_READ, 8'd0, 16'h0000);           // repeated read by holder
    send_req(FUNC_WRITE, 8'd255, 16'hFFFF);
    send_req(FUNC_READ, 8'd255, 16'h1234);         // queued behind writer
    send_req(FUNC_READ, 8'd255, 16'h1234);         // duplicate waiter
    send_req(FUNC_WRITE, 8'd255, 16'h0001);
    send_req(FUNC_RELEASE, 8'd255, 16'hFFFF);      // wakes reader run
    send_req(FUNC_RELEASE, 8'd255, 16'h1234);      // wakes writer
    send_req(FUNC_RELEASE, 8'd255, 16'h0001);
    send_req(FUNC_UNUSED, 8'd10, 16'hAAAA);        // unused func
    send_req(FUNC_RELEASE, 8'd0, 16'h5555);        // non-holder release
    for (int i = 1; i < 17; i++) send_req(FUNC_READ, 8'd0, 16'(i));  // fills holders
    send_req(FUNC_RELEASE, 8'd0, 16'h0000);
    for (int i = 0; i < 17; i++) send_req(FUNC_WRITE, 8'd0, 16'h100 + 16'(i)); // queue full
    for (int i = 1; i < 17; i++) send_req(FUNC_RELEASE, 8'd0, 16'(i));
    for (int i = 0; i < 16; i++) send_req(FUNC_RELEASE, 8'd0, 16'h100 + 16'(i));

    // Random: few keys and txns for contention, some wide-range noise.
    out_idle_on = 1'b1;
    for (int n = 0; n < 125; n++) begin
      if (n % 50 == 40) out_idle_on = ~out_idle_on;
      if ($urandom_range(0, 9) == 0) begin
        f = 2'($urandom);
        k = 8'($urandom);
        t = 16'($urandom);
      end else begin
        f = ($urandom_range(0, 2) == 0) ? FUNC_RELEASE
          : ($urandom_range(0, 2) == 0 ? FUNC_WRITE : FUNC_READ);
        k = 8'($urandom_range(0, 3));
        t = 16'($urandom_range(0, 11));
      end
      send_req(f, k, t);
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
